/* src/saz2c_pkg.sv */
// Shared types, result kind codes and fixed-point helpers for the spherical to Cartesian block.
// Used by the CORDIC lane, the top level and the checker; depends on nothing else.
`default_nettype none

package saz2c_pkg;

	localparam int ANGLE_BITS_DEF = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int CORDIC_STEPS = 30;
	localparam int TRIG_W = 34;
	localparam int Z_W = 33;
	localparam int INT_W = 40;
	localparam int MUL_W = 36;

	localparam logic signed [TRIG_W-1:0] CORDIC_X0 = TRIG_W'(652032874);

	localparam logic [2:0] KIND_STATE = 3'd0;
	localparam logic [2:0] KIND_D_RADIUS = 3'd1;
	localparam logic [2:0] KIND_D_RA = 3'd2;
	localparam logic [2:0] KIND_D_DEC = 3'd3;
	localparam logic [2:0] KIND_D_SPEED = 3'd4;
	localparam logic [2:0] KIND_D_AZ = 3'd5;
	localparam logic [2:0] KIND_D_FPA = 3'd6;

	typedef logic signed [INT_W-1:0] wide_t;
	typedef logic signed [TRIG_W-1:0] trig_t;

	function automatic logic signed [Z_W-1:0] atan_turn(input int i);
		logic signed [Z_W-1:0] v;
		unique case (i)
			0: v = Z_W'(536870912);
			1: v = Z_W'(316933406);
			2: v = Z_W'(167458907);
			3: v = Z_W'(85004756);
			4: v = Z_W'(42667331);
			5: v = Z_W'(21354465);
			6: v = Z_W'(10679838);
			7: v = Z_W'(5340245);
			8: v = Z_W'(2670163);
			9: v = Z_W'(1335087);
			10: v = Z_W'(667544);
			11: v = Z_W'(333772);
			12: v = Z_W'(166886);
			13: v = Z_W'(83443);
			14: v = Z_W'(41722);
			15: v = Z_W'(20861);
			16: v = Z_W'(10430);
			17: v = Z_W'(5215);
			18: v = Z_W'(2608);
			19: v = Z_W'(1304);
			20: v = Z_W'(652);
			21: v = Z_W'(326);
			22: v = Z_W'(163);
			23: v = Z_W'(81);
			24: v = Z_W'(41);
			25: v = Z_W'(20);
			26: v = Z_W'(10);
			27: v = Z_W'(5);
			28: v = Z_W'(3);
			29: v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	// Q1.30 product with round half up.
	function automatic wide_t mq(input wide_t a, input wide_t b);
		logic signed [MUL_W-1:0] an;
		logic signed [MUL_W-1:0] bn;
		logic signed [2*MUL_W-1:0] p;
		an = MUL_W'(a);
		bn = MUL_W'(b);
		p = an * bn;
		p = p + (2*MUL_W)'(64'sd1 <<< 29);
		return INT_W'(p >>> 30);
	endfunction

	function automatic wide_t clamp2(input wide_t x);
		wide_t lim;
		lim = INT_W'(64'sd1 <<< 31);
		if (x > lim) begin
			return lim;
		end else if (x < -lim) begin
			return -lim;
		end
		return x;
	endfunction

	function automatic wide_t to_q16(input wide_t x);
		return (x + INT_W'(64'sd1 <<< 13)) >>> 14;
	endfunction

endpackage

`default_nettype wire

/* src/spherical_azfpa_to_cartesian.sv */
// Spherical orbital state to Cartesian position and velocity, with optional Jacobian columns.
// A new input beat can enter every cycle unless the pipeline is held; each input yields one
// result beat, or seven when the Jacobian is requested, and the single result port holds the
// input until the last beat of a burst is taken. A stall on the result port holds the whole
// pipeline.
// The asynchronous active-low reset clears the valid bits and the beat counter only.
`default_nettype none

module spherical_azfpa_to_cartesian #(
	parameter int ANGLE_BITS = saz2c_pkg::ANGLE_BITS_DEF,
	parameter int VALUE_BITS = saz2c_pkg::VALUE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// radius, right_ascension, declination, speed, azimuth, flight_path_angle
	input wire logic [((62+4*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
	// want_jacobian
	input wire logic [0:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// value_x, value_y, value_z, value_vx, value_vy, value_vz
	output logic [((6*VALUE_BITS+7)/8)*8-1:0] m_tdata,
	// kind
	output logic [2:0] m_tuser,
	output logic m_tlast
);
	import saz2c_pkg::*;

	localparam int CL = CORDIC_STEPS + 2;
	localparam int OUT_W = ((6*VALUE_BITS+7)/8)*8;

	logic adv;
	logic [ANGLE_BITS-1:0] ang_raw [4];
	logic [31:0] turn [4];
	trig_t cos_w [4];
	trig_t sin_w [4];
	wide_t tc [4];
	wide_t ts [4];

	assign ang_raw[0] = s_tdata[31 +: ANGLE_BITS];
	assign ang_raw[1] = s_tdata[31+ANGLE_BITS +: ANGLE_BITS];
	assign ang_raw[2] = s_tdata[62+2*ANGLE_BITS +: ANGLE_BITS];
	assign ang_raw[3] = s_tdata[62+3*ANGLE_BITS +: ANGLE_BITS];

	for (genvar g = 0; g < 4; g++) begin : g_lane
		if (ANGLE_BITS >= 32) begin : g_trunc
			assign turn[g] = ang_raw[g][ANGLE_BITS-1 -: 32];
		end else begin : g_shift
			assign turn[g] = {ang_raw[g], {(32-ANGLE_BITS){1'b0}}};
		end
		saz2c_cordic u_cordic (
			.clk(clk),
			.en(adv),
			.angle(turn[g]),
			.cos_v(cos_w[g]),
			.sin_v(sin_w[g])
		);
		assign tc[g] = INT_W'(cos_w[g]);
		assign ts[g] = INT_W'(sin_w[g]);
	end

	logic cv_s [0:CL-1];
	logic [30:0] r_cs [0:CL-1];
	logic [30:0] v_cs [0:CL-1];
	logic want_cs [0:CL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CL; i++) begin
				cv_s[i] <= 1'b0;
			end
		end else if (adv) begin
			cv_s[0] <= s_tvalid;
			for (int i = 1; i < CL; i++) begin
				cv_s[i] <= cv_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_cs[0] <= s_tdata[30:0];
			v_cs[0] <= s_tdata[31+2*ANGLE_BITS +: 31];
			want_cs[0] <= s_tuser[0];
			for (int i = 1; i < CL; i++) begin
				r_cs[i] <= r_cs[i-1];
				v_cs[i] <= v_cs[i-1];
				want_cs[i] <= want_cs[i-1];
			end
		end
	end

	logic v1_s, v2_s, v3_s, v4_s, v5_s;
	logic [2:0] cnt_q;
	logic beat_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
			v4_s <= 1'b0;
			v5_s <= 1'b0;
		end else if (adv) begin
			v1_s <= cv_s[CL-1];
			v2_s <= v1_s;
			v3_s <= v2_s;
			v4_s <= v3_s;
			v5_s <= v4_s;
		end
	end

	wide_t r_w, v_w;
	assign r_w = INT_W'($signed({1'b0, r_cs[CL-1]}));
	assign v_w = INT_W'($signed({1'b0, v_cs[CL-1]}));

	wide_t cRcD_s1, sRcD_s1, cRsD_s1, sRsD_s1, cAcR_s1, cAsR_s1, cDcA_s1, sAsR_s1;
	wide_t cRsA_s1, cFcD_s1, cAsD_s1, cDsA_s1, cFsD_s1, sFsD_s1, st2_s1, j22_s1;
	wide_t cR_s1, sR_s1, sD_s1, cF_s1, sF_s1, sA_s1, r_s1, v_s1;
	logic want_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cRcD_s1 <= mq(tc[0], tc[1]);
			sRcD_s1 <= mq(ts[0], tc[1]);
			cRsD_s1 <= mq(tc[0], ts[1]);
			sRsD_s1 <= mq(ts[0], ts[1]);
			cAcR_s1 <= mq(tc[2], tc[0]);
			cAsR_s1 <= mq(tc[2], ts[0]);
			cDcA_s1 <= mq(tc[1], tc[2]);
			sAsR_s1 <= mq(ts[2], ts[0]);
			cRsA_s1 <= mq(tc[0], ts[2]);
			cFcD_s1 <= mq(tc[3], tc[1]);
			cAsD_s1 <= mq(tc[2], ts[1]);
			cDsA_s1 <= mq(tc[1], ts[2]);
			cFsD_s1 <= mq(tc[3], ts[1]);
			sFsD_s1 <= mq(ts[3], ts[1]);
			st2_s1 <= mq(r_w, ts[1]);
			j22_s1 <= mq(r_w, tc[1]);
			cR_s1 <= tc[0];
			sR_s1 <= ts[0];
			sD_s1 <= ts[1];
			cF_s1 <= tc[3];
			sF_s1 <= ts[3];
			sA_s1 <= ts[2];
			r_s1 <= r_w;
			v_s1 <= v_w;
			want_s1 <= want_cs[CL-1];
		end
	end

	wide_t aa_s2, bb_s2, cFcRcD_s2, cFsRcD_s2, sFcDcA_s2, st0_s2, st1_s2, j20n_s2, j21n_s2;
	wide_t sFcAsD_s2, cRsDsA_s2, sRsDsA_s2, sFcDsA_s2, sFcRcD_s2, sFsRcD_s2, cFcDcA_s2;
	wide_t j00_s2, j01_s2, j02_s2;
	wide_t sAsR_s2, cRsA_s2, cAsR_s2, cAcR_s2, cFcD_s2, cFsD_s2, sFsD_s2;
	wide_t cR_s2, sR_s2, cF_s2, sF_s2, v_s2, st2_s2, j22_s2;
	logic want_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			aa_s2 <= mq(cAcR_s1, sD_s1);
			bb_s2 <= mq(cAsR_s1, sD_s1);
			cFcRcD_s2 <= mq(cF_s1, cRcD_s1);
			cFsRcD_s2 <= mq(cF_s1, sRcD_s1);
			sFcDcA_s2 <= mq(sF_s1, cDcA_s1);
			st0_s2 <= mq(r_s1, cRcD_s1);
			st1_s2 <= mq(r_s1, sRcD_s1);
			j20n_s2 <= mq(r_s1, cRsD_s1);
			j21n_s2 <= mq(r_s1, sRsD_s1);
			sFcAsD_s2 <= mq(sF_s1, cAsD_s1);
			cRsDsA_s2 <= mq(cRsD_s1, sA_s1);
			sRsDsA_s2 <= mq(sRsD_s1, sA_s1);
			sFcDsA_s2 <= mq(sF_s1, cDsA_s1);
			sFcRcD_s2 <= mq(sF_s1, cRcD_s1);
			sFsRcD_s2 <= mq(sF_s1, sRcD_s1);
			cFcDcA_s2 <= mq(cF_s1, cDcA_s1);
			j00_s2 <= to_q16(cRcD_s1);
			j01_s2 <= to_q16(sRcD_s1);
			j02_s2 <= to_q16(sD_s1);
			sAsR_s2 <= sAsR_s1;
			cRsA_s2 <= cRsA_s1;
			cAsR_s2 <= cAsR_s1;
			cAcR_s2 <= cAcR_s1;
			cFcD_s2 <= cFcD_s1;
			cFsD_s2 <= cFsD_s1;
			sFsD_s2 <= sFsD_s1;
			cR_s2 <= cR_s1;
			sR_s2 <= sR_s1;
			cF_s2 <= cF_s1;
			sF_s2 <= sF_s1;
			v_s2 <= v_s1;
			st2_s2 <= st2_s1;
			j22_s2 <= j22_s1;
			want_s2 <= want_s1;
		end
	end

	wide_t a3, b3, uz3;
	assign a3 = clamp2(sAsR_s2 + aa_s2);
	assign b3 = clamp2(cRsA_s2 - bb_s2);
	assign uz3 = clamp2(cFsD_s2 + sFcDcA_s2);

	wide_t sFA_s3, sFB_s3, cFA_s3, cFB_s3, cRuz_s3, sRuz_s3, t43_s3, t44_s3;
	wide_t uz_s3, d25_s3, d45_s3, d55_s3, j35_s3;
	wide_t cFcRcD_s3, sFcRcD_s3, cFsRcD_s3, sFsRcD_s3, v_s3, st0_s3, st1_s3, st2_s3;
	wide_t j00_s3, j01_s3, j02_s3, j20n_s3, j21n_s3, j22_s3;
	logic want_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sFA_s3 <= mq(sF_s2, a3);
			sFB_s3 <= mq(sF_s2, b3);
			cFA_s3 <= mq(cF_s2, a3);
			cFB_s3 <= mq(cF_s2, b3);
			cRuz_s3 <= mq(cR_s2, uz3);
			sRuz_s3 <= mq(sR_s2, uz3);
			t43_s3 <= mq(sF_s2, cAsR_s2 - cRsDsA_s2);
			t44_s3 <= mq(sF_s2, cAcR_s2 + sRsDsA_s2);
			uz_s3 <= uz3;
			d25_s3 <= clamp2(cFcD_s2 - sFcAsD_s2);
			d45_s3 <= clamp2(sFcDsA_s2);
			d55_s3 <= clamp2(cFcDcA_s2 - sFsD_s2);
			j35_s3 <= to_q16(uz3);
			cFcRcD_s3 <= cFcRcD_s2;
			sFcRcD_s3 <= sFcRcD_s2;
			cFsRcD_s3 <= cFsRcD_s2;
			sFsRcD_s3 <= sFsRcD_s2;
			v_s3 <= v_s2;
			st0_s3 <= st0_s2;
			st1_s3 <= st1_s2;
			st2_s3 <= st2_s2;
			j00_s3 <= j00_s2;
			j01_s3 <= j01_s2;
			j02_s3 <= j02_s2;
			j20n_s3 <= j20n_s2;
			j21n_s3 <= j21n_s2;
			j22_s3 <= j22_s2;
			want_s3 <= want_s2;
		end
	end

	wide_t ux4, uy4;
	assign ux4 = clamp2(cFcRcD_s3 - sFA_s3);
	assign uy4 = clamp2(sFB_s3 + cFsRcD_s3);

	wide_t ux_s4, uy_s4, uz_s4, d53_s4, d54_s4, c23_s4, c24_s4, c43_s4, c44_s4;
	wide_t d25_s4, d45_s4, d55_s4, j33_s4, j34_s4, j35_s4;
	wide_t v_s4, st0_s4, st1_s4, st2_s4, j00_s4, j01_s4, j02_s4, j20n_s4, j21n_s4, j22_s4;
	logic want_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ux_s4 <= ux4;
			uy_s4 <= uy4;
			uz_s4 <= uz_s3;
			d53_s4 <= clamp2(cFA_s3 + sFcRcD_s3);
			d54_s4 <= clamp2(cFB_s3 - sFsRcD_s3);
			c23_s4 <= clamp2(cRuz_s3);
			c24_s4 <= clamp2(sRuz_s3);
			c43_s4 <= clamp2(t43_s3);
			c44_s4 <= clamp2(t44_s3);
			d25_s4 <= d25_s3;
			d45_s4 <= d45_s3;
			d55_s4 <= d55_s3;
			j33_s4 <= to_q16(ux4);
			j34_s4 <= to_q16(uy4);
			j35_s4 <= j35_s3;
			v_s4 <= v_s3;
			st0_s4 <= st0_s3;
			st1_s4 <= st1_s3;
			st2_s4 <= st2_s3;
			j00_s4 <= j00_s3;
			j01_s4 <= j01_s3;
			j02_s4 <= j02_s3;
			j20n_s4 <= j20n_s3;
			j21n_s4 <= j21n_s3;
			j22_s4 <= j22_s3;
			want_s4 <= want_s3;
		end
	end

	wide_t st3_s5, st4_s5, st5_s5, j23n_s5, j24n_s5, j25_s5, j43n_s5, j44_s5, j45n_s5;
	wide_t j53n_s5, j54_s5, j55_s5, j33_s5, j34_s5, j35_s5;
	wide_t st0_s5, st1_s5, st2_s5, j00_s5, j01_s5, j02_s5, j20n_s5, j21n_s5, j22_s5;
	logic want_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			st3_s5 <= mq(v_s4, ux_s4);
			st4_s5 <= mq(v_s4, uy_s4);
			st5_s5 <= mq(v_s4, uz_s4);
			j23n_s5 <= mq(v_s4, c23_s4);
			j24n_s5 <= mq(v_s4, c24_s4);
			j25_s5 <= mq(v_s4, d25_s4);
			j43n_s5 <= mq(v_s4, c43_s4);
			j44_s5 <= mq(v_s4, c44_s4);
			j45n_s5 <= mq(v_s4, d45_s4);
			j53n_s5 <= mq(v_s4, d53_s4);
			j54_s5 <= mq(v_s4, d54_s4);
			j55_s5 <= mq(v_s4, d55_s4);
			j33_s5 <= j33_s4;
			j34_s5 <= j34_s4;
			j35_s5 <= j35_s4;
			st0_s5 <= st0_s4;
			st1_s5 <= st1_s4;
			st2_s5 <= st2_s4;
			j00_s5 <= j00_s4;
			j01_s5 <= j01_s4;
			j02_s5 <= j02_s4;
			j20n_s5 <= j20n_s4;
			j21n_s5 <= j21n_s4;
			j22_s5 <= j22_s4;
			want_s5 <= want_s4;
		end
	end

	assign beat_last = !want_s5 || (cnt_q == KIND_D_FPA);
	assign adv = !v5_s || (m_tready && beat_last);
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= KIND_STATE;
		end else if (v5_s && m_tready) begin
			if (beat_last) begin
				cnt_q <= KIND_STATE;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	wide_t col [6];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			col[j] = '0;
		end
		unique case (cnt_q)
			KIND_STATE: begin
				col[0] = st0_s5;
				col[1] = st1_s5;
				col[2] = st2_s5;
				col[3] = st3_s5;
				col[4] = st4_s5;
				col[5] = st5_s5;
			end
			KIND_D_RADIUS: begin
				col[0] = j00_s5;
				col[1] = j01_s5;
				col[2] = j02_s5;
			end
			KIND_D_RA: begin
				col[0] = -st1_s5;
				col[1] = st0_s5;
				col[3] = -st4_s5;
				col[4] = st3_s5;
			end
			KIND_D_DEC: begin
				col[0] = -j20n_s5;
				col[1] = -j21n_s5;
				col[2] = j22_s5;
				col[3] = -j23n_s5;
				col[4] = -j24n_s5;
				col[5] = j25_s5;
			end
			KIND_D_SPEED: begin
				col[3] = j33_s5;
				col[4] = j34_s5;
				col[5] = j35_s5;
			end
			KIND_D_AZ: begin
				col[3] = -j43n_s5;
				col[4] = j44_s5;
				col[5] = -j45n_s5;
			end
			KIND_D_FPA: begin
				col[3] = -j53n_s5;
				col[4] = j54_s5;
				col[5] = j55_s5;
			end
			default: begin
				col[0] = '0;
			end
		endcase
	end

	logic [VALUE_BITS-1:0] val [6];

	for (genvar j = 0; j < 6; j++) begin : g_sat
		if (VALUE_BITS >= INT_W) begin : g_ext
			assign val[j] = VALUE_BITS'(col[j]);
		end else begin : g_clip
			logic fits;
			assign fits = (col[j][INT_W-1:VALUE_BITS-1] == {(INT_W-VALUE_BITS+1){1'b0}})
				|| (col[j][INT_W-1:VALUE_BITS-1] == {(INT_W-VALUE_BITS+1){1'b1}});
			assign val[j] = fits ? col[j][VALUE_BITS-1:0]
				: (col[j][INT_W-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
				: {1'b0, {(VALUE_BITS-1){1'b1}}});
		end
	end

	assign m_tvalid = v5_s;
	assign m_tuser = cnt_q;
	assign m_tlast = beat_last;
	assign m_tdata = OUT_W'({val[5], val[4], val[3], val[2], val[1], val[0]});

endmodule

`default_nettype wire

/* src/saz2c_cordic.sv */
// Pipelined rotation-mode CORDIC giving cosine and sine of a 32-bit binary angle in Q1.30.
// One input stage, one stage per iteration and one quadrant mapping stage; uses saz2c_pkg.
`default_nettype none

module saz2c_cordic (
	input wire logic clk,
	input wire logic en,
	input wire logic [31:0] angle,
	output saz2c_pkg::trig_t cos_v,
	output saz2c_pkg::trig_t sin_v
);
	import saz2c_pkg::*;

	trig_t x_s [0:CORDIC_STEPS];
	trig_t y_s [0:CORDIC_STEPS];
	logic signed [Z_W-1:0] z_s [0:CORDIC_STEPS];
	logic [1:0] q_s [0:CORDIC_STEPS];

	logic [1:0] quad;
	logic [31:0] resid;

	assign quad = 2'((angle + 32'h2000_0000) >> 30);
	assign resid = angle - {quad, 30'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_X0;
			y_s[0] <= '0;
			z_s[0] <= Z_W'($signed(resid));
			q_s[0] <= quad;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_turn(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (q_s[CORDIC_STEPS])
				2'd0: begin
					cos_v <= x_s[CORDIC_STEPS];
					sin_v <= y_s[CORDIC_STEPS];
				end
				2'd1: begin
					cos_v <= -y_s[CORDIC_STEPS];
					sin_v <= x_s[CORDIC_STEPS];
				end
				2'd2: begin
					cos_v <= -x_s[CORDIC_STEPS];
					sin_v <= -y_s[CORDIC_STEPS];
				end
				default: begin
					cos_v <= y_s[CORDIC_STEPS];
					sin_v <= -x_s[CORDIC_STEPS];
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/saz2c_checker.sv */
// Port-level checker for the spherical to Cartesian block, bound to the top level.
// Watches the result port only; uses saz2c_pkg for the kind codes.
`default_nettype none

module saz2c_checker #(
	parameter int VALUE_BITS = saz2c_pkg::VALUE_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [((6*VALUE_BITS+7)/8)*8-1:0] m_tdata,
	input wire logic [2:0] m_tuser,
	input wire logic m_tlast
);
	import saz2c_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result beat changed while stalled.");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("Jacobian burst broke off.");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tuser == $past(m_tuser) + 3'd1)
		else $error("Result kinds out of order.");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_STATE || m_tuser == KIND_D_FPA)
		else $error("Last beat has a wrong kind.");

endmodule

bind spherical_azfpa_to_cartesian saz2c_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);

`default_nettype wire
